### src/sum_checked_frame_receiver_assert.svh
// Assertion macros for the frame receiver.
`ifndef SUM_CHECKED_FRAME_RECEIVER_ASSERT_SVH
`define SUM_CHECKED_FRAME_RECEIVER_ASSERT_SVH

`ifndef SYNTHESIS
// Same-cycle implication, checked on aclk outside reset.
`define SCFR_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("frame receiver assertion failed");
// Next-cycle implication, checked on aclk outside reset.
`define SCFR_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("frame receiver assertion failed");
`else
`define SCFR_ASSERT_NOW(label, ante, cons)
`define SCFR_ASSERT_NEXT(label, ante, cons)
`endif

`endif

### src/scfr_pkg.sv
// Types and constants for the frame receiver.
`timescale 1ns / 1ps
`default_nettype none

package scfr_pkg;

    localparam int TICK_COUNTER_WIDTH = 16;
    localparam int TICK_CMP_W = (TICK_COUNTER_WIDTH > 16) ? TICK_COUNTER_WIDTH : 16;

    localparam logic [7:0] HEADER_BYTE = 8'hF0;

    localparam logic OP_BYTE = 1'b0;
    localparam logic OP_TICK = 1'b1;

    localparam logic REG_TIMEOUT = 1'b0;
    localparam logic REG_MAX_LEN = 1'b1;

    localparam logic [15:0] TIMEOUT_RESET = 16'd5;
    localparam logic [7:0]  MAX_LEN_RESET = 8'd125;

    typedef enum logic [1:0] {
        PH_IDLE  = 2'd0,
        PH_LEN   = 2'd1,
        PH_BODY  = 2'd2,
        PH_CHECK = 2'd3
    } phase_t;

    typedef enum logic [2:0] {
        ST_PROGRESS   = 3'd0,
        ST_GOOD       = 3'd1,
        ST_BAD_HEADER = 3'd2,
        ST_BAD_SUM    = 3'd3,
        ST_TIMEOUT    = 3'd4,
        ST_TOO_LONG   = 3'd5
    } status_t;

    typedef struct packed {
        logic [7:0] data_byte;
        logic [7:0] position;
        status_t    status;
        logic       frame_end;
    } result_t;

endpackage

`default_nettype wire

### src/sum_checked_frame_receiver.sv
// Header/length/checksum frame receiver with APB configuration.
// Each received byte gives a result on m_*, held in the output or skid register.
// Throughput: one item (byte or tick) per cycle; a two-entry output stage
// (output register plus skid register) keeps s_ready high until two results wait.
// Ticks give a result only when they abort an open frame by timeout.
// Reset (aresetn low, synchronous): idle, counters zero, registers to defaults.
`timescale 1ns / 1ps
`default_nettype none

`include "sum_checked_frame_receiver_assert.svh"

module sum_checked_frame_receiver
    import scfr_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,

    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic        s_operation,
    input  wire logic [7:0]  s_rx_byte,

    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [7:0]       m_data_byte,
    output logic [7:0]       m_position,
    output logic [2:0]       m_status,
    output logic             m_frame_end,

    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    // configuration
    logic [15:0] timeout_reg;
    logic [7:0]  max_len_reg;
    logic        cfg_write;

    assign pready    = 1'b1;
    assign cfg_write = psel & penable & pwrite;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            timeout_reg <= TIMEOUT_RESET;
            max_len_reg <= MAX_LEN_RESET;
        end else if (cfg_write) begin
            case (paddr[2])
                REG_TIMEOUT: timeout_reg <= pwdata[15:0];
                REG_MAX_LEN: max_len_reg <= pwdata[7:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[2])
            REG_TIMEOUT: prdata = {16'd0, timeout_reg};
            REG_MAX_LEN: prdata = {24'd0, max_len_reg};
            default:     prdata = 32'd0;
        endcase
    end

    // frame state
    phase_t                        phase_reg, phase_next;
    logic [7:0]                    left_reg, left_next;
    logic [7:0]                    sum_reg, sum_next;
    logic [7:0]                    index_reg, index_next;
    logic [TICK_COUNTER_WIDTH-1:0] ticks_reg, ticks_next;
    logic [TICK_COUNTER_WIDTH-1:0] ticks_inc;
    logic [7:0]                    left_dec;
    logic                          s_accept;
    logic                          res_valid;
    result_t                       res;

    assign s_accept  = s_valid & s_ready;
    assign ticks_inc = (ticks_reg == '1) ? ticks_reg : ticks_reg + 1'b1;
    assign left_dec  = left_reg - 8'd1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_IDLE;
            left_reg  <= 8'd0;
            sum_reg   <= 8'd0;
            index_reg <= 8'd0;
            ticks_reg <= '0;
        end else begin
            phase_reg <= phase_next;
            left_reg  <= left_next;
            sum_reg   <= sum_next;
            index_reg <= index_next;
            ticks_reg <= ticks_next;
        end
    end

    always_comb begin
        phase_next = phase_reg;
        left_next  = left_reg;
        sum_next   = sum_reg;
        index_next = index_reg;
        ticks_next = ticks_reg;
        res_valid  = 1'b0;
        res        = '{data_byte: s_rx_byte, position: index_reg,
                       status: ST_PROGRESS, frame_end: 1'b0};

        if (s_accept) begin
            if (s_operation == OP_TICK) begin
                if (phase_reg != PH_IDLE) begin
                    if (TICK_CMP_W'(ticks_inc) > TICK_CMP_W'(timeout_reg)) begin
                        phase_next    = PH_IDLE;
                        left_next     = 8'd0;
                        sum_next      = 8'd0;
                        index_next    = 8'd0;
                        ticks_next    = '0;
                        res_valid     = 1'b1;
                        res.data_byte = 8'd0;
                        res.status    = ST_TIMEOUT;
                        res.frame_end = 1'b1;
                    end else begin
                        ticks_next = ticks_inc;
                    end
                end
            end else begin
                res_valid = 1'b1;
                case (phase_reg)
                    PH_IDLE: begin
                        res.position = 8'd0;
                        if (s_rx_byte != HEADER_BYTE) begin
                            res.status    = ST_BAD_HEADER;
                            res.frame_end = 1'b1;
                        end else begin
                            phase_next = PH_LEN;
                            left_next  = 8'd0;
                            sum_next   = 8'd0;
                            ticks_next = '0;
                            index_next = 8'd1;
                        end
                    end
                    PH_LEN: begin
                        if (s_rx_byte > max_len_reg) begin
                            phase_next    = PH_IDLE;
                            left_next     = 8'd0;
                            sum_next      = 8'd0;
                            index_next    = 8'd0;
                            ticks_next    = '0;
                            res.status    = ST_TOO_LONG;
                            res.frame_end = 1'b1;
                        end else begin
                            left_next  = s_rx_byte;
                            phase_next = (s_rx_byte == 8'd0) ? PH_CHECK : PH_BODY;
                            index_next = index_reg + 8'd1;
                        end
                    end
                    PH_BODY: begin
                        sum_next   = sum_reg + s_rx_byte;
                        left_next  = left_dec;
                        index_next = index_reg + 8'd1;
                        if (left_dec == 8'd0) begin
                            phase_next = PH_CHECK;
                        end
                    end
                    PH_CHECK: begin
                        phase_next    = PH_IDLE;
                        left_next     = 8'd0;
                        sum_next      = 8'd0;
                        index_next    = 8'd0;
                        ticks_next    = '0;
                        res.status    = (s_rx_byte == sum_reg) ? ST_GOOD : ST_BAD_SUM;
                        res.frame_end = 1'b1;
                    end
                    default: begin
                        phase_next = PH_IDLE;
                    end
                endcase
            end
        end
    end

    // output register plus skid register
    logic    m_valid_reg, m_valid_next;
    logic    skid_valid_reg, skid_valid_next;
    result_t out_reg, out_next;
    result_t skid_reg, skid_next;

    assign s_ready = ~skid_valid_reg;

    always_comb begin
        m_valid_next    = m_valid_reg;
        skid_valid_next = skid_valid_reg;
        out_next        = out_reg;
        skid_next       = skid_reg;
        if (m_valid_reg && m_ready) begin
            m_valid_next    = skid_valid_reg;
            out_next        = skid_reg;
            skid_valid_next = 1'b0;
        end
        if (res_valid) begin
            if (!m_valid_next) begin
                m_valid_next = 1'b1;
                out_next     = res;
            end else begin
                skid_valid_next = 1'b1;
                skid_next       = res;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg    <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            m_valid_reg    <= m_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        out_reg  <= out_next;
        skid_reg <= skid_next;
    end

    assign m_valid     = m_valid_reg;
    assign m_data_byte = out_reg.data_byte;
    assign m_position  = out_reg.position;
    assign m_status    = out_reg.status;
    assign m_frame_end = out_reg.frame_end;

    // checks
    `SCFR_ASSERT_NOW(a_skid_behind_out, skid_valid_reg, m_valid_reg)
    `SCFR_ASSERT_NOW(a_idle_clear, phase_reg == PH_IDLE,
        (index_reg == 8'd0) && (sum_reg == 8'd0) && (ticks_reg == '0))
    `SCFR_ASSERT_NOW(a_end_matches_status, m_valid_reg,
        m_frame_end == (out_reg.status != ST_PROGRESS))
    `SCFR_ASSERT_NEXT(a_byte_gives_result, s_accept && (s_operation == OP_BYTE), m_valid_reg)
    `SCFR_ASSERT_NEXT(a_idle_tick_no_change,
        s_accept && (s_operation == OP_TICK) && (phase_reg == PH_IDLE), phase_reg == PH_IDLE)

endmodule

`default_nettype wire
